@@ hdl/ceb_pkg.sv @@
// Shared widths, codes, reset values and the item tag type of the calorimeter event builder.
`timescale 1ns / 1ps

package ceb_pkg;

    // Field widths.
    localparam int ADC_W       = 14;
    localparam int PED_W       = 18;
    localparam int GAIN_W      = 11;
    localparam int GAIN_FRAC   = 10;
    localparam int CH_W        = 4;
    localparam int ENERGY_W    = 19;
    localparam int SUM_W       = 23;
    localparam int DIFF_W      = 20;
    localparam int PROD_W      = PED_W + GAIN_W;
    localparam int ZS_W        = 18;
    localparam int RUN_W       = 4;
    localparam int SPILL_W     = 16;
    localparam int COUNT_W     = 4;
    localparam int POS_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;

    // Command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Detector sources.
    typedef enum logic [1:0] {
        SRC_HODO = 2'd0,
        SRC_CAL  = 2'd1,
        SRC_TRIG = 2'd2,
        SRC_CHER = 2'd3
    } source_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HODO_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HIT_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SUPPRESS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSER_TRIGGER_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSER_RUN_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPILL_GAP_COUNT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHERENKOV_MIN      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MONITOR_CHANNEL    = 3'd7;

    // Configuration reset values.
    localparam logic [ADC_W-1:0]   RST_HODO_THRESHOLD     = 14'd250;
    localparam logic [ADC_W-1:0]   RST_HIGH_HIT_LEVEL     = 14'd2275;
    localparam logic [ZS_W-1:0]    RST_ZERO_SUPPRESS      = 18'd54;
    localparam logic [ADC_W-1:0]   RST_PULSER_TRIGGER_MAX = 14'd130;
    localparam logic [RUN_W-1:0]   RST_PULSER_RUN_LENGTH  = 4'd10;
    localparam logic [SPILL_W-1:0] RST_SPILL_GAP_COUNT    = 16'd50;
    localparam logic [ADC_W-1:0]   RST_CHERENKOV_MIN      = 14'd100;
    localparam logic [CH_W-1:0]    RST_MONITOR_CHANNEL    = 4'd6;

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic                valid;
        logic                cmd;
        source_t             source;
        logic [CH_W-1:0]     channel;
        logic [ADC_W-1:0]    adc;
        logic                eoe;
    } ceb_tag_t;

endpackage

@@ hdl/ceb_stream_if.sv @@
// Sample and result channel interfaces of the calorimeter event builder.
`timescale 1ns / 1ps

interface ceb_sample_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [1:0]                     source;
    logic [ceb_pkg::CH_W-1:0]       channel;
    logic [ceb_pkg::ADC_W-1:0]      adc;
    logic [ceb_pkg::PED_W-1:0]      pedestal;
    logic [ceb_pkg::GAIN_W-1:0]     gain;
    logic                           end_of_event;

    modport src (
        output valid, cmd, source, channel, adc, pedestal, gain, end_of_event,
        input  ready
    );
    modport sink (
        input  valid, cmd, source, channel, adc, pedestal, gain, end_of_event,
        output ready
    );
endinterface

interface ceb_result_if;
    logic                           valid;
    logic                           ready;
    logic                           event_accepted;
    logic                           electron_flag;
    logic [ceb_pkg::COUNT_W-1:0]    row_count;
    logic [ceb_pkg::COUNT_W-1:0]    column_count;
    logic [ceb_pkg::POS_W-1:0]      row_index;
    logic [ceb_pkg::POS_W-1:0]      column_index;
    logic                           high_hit;
    logic [ceb_pkg::SUM_W-1:0]      energy_sum;
    logic [ceb_pkg::CH_W-1:0]       peak_tower;
    logic [ceb_pkg::ENERGY_W-1:0]   monitor_energy;
    logic [ceb_pkg::SPILL_W-1:0]    spill_number;

    modport src (
        output valid, event_accepted, electron_flag, row_count, column_count,
               row_index, column_index, high_hit, energy_sum, peak_tower,
               monitor_energy, spill_number,
        input  ready
    );
    modport sink (
        input  valid, event_accepted, electron_flag, row_count, column_count,
               row_index, column_index, high_hit, energy_sum, peak_tower,
               monitor_energy, spill_number,
        output ready
    );
endinterface

@@ hdl/ceb_energy.sv @@
// Calibration memories and the three-stage tower energy pipeline.
`timescale 1ns / 1ps

module ceb_energy #(
    parameter int CAL_CHANNELS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  ceb_pkg::ceb_tag_t                   tag_in,
    input  logic [ceb_pkg::PED_W-1:0]           pedestal,
    input  logic [ceb_pkg::GAIN_W-1:0]          gain,
    input  logic [ceb_pkg::ZS_W-1:0]            zero_suppress_level,
    output ceb_pkg::ceb_tag_t                   tag_out,
    output logic [ceb_pkg::ENERGY_W-1:0]        energy
);
    import ceb_pkg::*;

    localparam int CAL_AW = (CAL_CHANNELS > 1) ? $clog2(CAL_CHANNELS) : 1;

    logic [PED_W-1:0]    ped_mem  [CAL_CHANNELS];
    logic [GAIN_W-1:0]   gain_mem [CAL_CHANNELS];

    logic [CAL_AW-1:0]   addr;
    logic                in_range;
    logic                load_we;

    ceb_tag_t            s1_tag_reg;
    ceb_tag_t            s2_tag_reg;
    ceb_tag_t            s3_tag_reg;
    logic [PED_W-1:0]    ped_rd_reg;
    logic [GAIN_W-1:0]   gain_rd_reg;
    logic [PED_W-1:0]    s2_diff_reg;
    logic [GAIN_W-1:0]   s2_gain_reg;
    logic [ENERGY_W-1:0] s3_energy_reg;

    logic [DIFF_W-1:0]   diff;
    logic                pass;
    logic [PED_W-1:0]    diff_kept;
    logic [PROD_W-1:0]   product;

    assign addr     = CAL_AW'(tag_in.channel);
    assign in_range = 32'(tag_in.channel) < CAL_CHANNELS;
    assign load_we  = tag_in.valid && en && (tag_in.cmd == CMD_LOAD) && in_range;

    // The calibration tables: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            ped_mem[addr]  <= pedestal;
            gain_mem[addr] <= gain;
        end
        if (en)
        begin
            ped_rd_reg  <= ped_mem[addr];
            gain_rd_reg <= gain_mem[addr];
        end
    end

    // Pedestal subtraction in sixteenth counts, then zero suppression.
    always_comb
    begin
        diff      = {2'b00, s1_tag_reg.adc, 4'b0000} - {2'b00, ped_rd_reg};
        pass      = !diff[DIFF_W-1] && (diff[DIFF_W-2:0] > {1'b0, zero_suppress_level});
        diff_kept = pass ? diff[PED_W-1:0] : '0;
    end

    // Gain in Q1.10; once the ten fraction bits are dropped, the product of an 18-bit
    // difference and the gain always fits 19 bits, so no saturation is needed.
    assign product = PROD_W'(s2_diff_reg) * PROD_W'(s2_gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else if (en)
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_diff_reg   <= diff_kept;
            s2_gain_reg   <= gain_rd_reg;
            s3_energy_reg <= product[PROD_W-1:GAIN_FRAC];
        end
    end

    assign tag_out = s3_tag_reg;
    assign energy  = s3_energy_reg;

endmodule

@@ hdl/calorimeter_event_builder_top.sv @@
// Top level of the calorimeter event builder.
`timescale 1ns / 1ps

// The event builder takes one ADC sample transaction per clock cycle and returns one result
// transaction for every sample transaction that carries end_of_event. Calibration loads
// (cmd = 1) write the per-tower pedestal and gain into two small synchronous memories;
// calorimeter samples read them back registered, go through pedestal subtraction and
// zero suppression, a registered gain multiply, and are then folded into the event sum,
// the peak-tower search and the monitor tower. Hodoscope samples set hit bits, and trigger
// and Cherenkov samples are latched. An item passes three pipeline stages before it
// reaches the event accumulators; at the end of an event they are copied into the finishing
// stage, and the finished result then moves into the output register. The
// sustained rate is one transaction per cycle; the only stall happens when a finished
// result waits in the finishing stage while the output register is still full and not
// taken, in which case the whole pipeline holds. Calorimeter channels at or above
// CAL_CHANNELS and hodoscope channels at or above HODO_CHANNELS are ignored; hodoscope
// channels below HODO_CHANNELS/2 are rows and the others are columns. Configuration
// registers are written through cfg_we, cfg_index and cfg_data and should only be written
// while no event is in flight. A tower must be loaded before its samples are sent.
module calorimeter_event_builder_top #(
    parameter int CAL_CHANNELS  = 16,
    parameter int HODO_CHANNELS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ceb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ceb_pkg::CFG_DATA_W-1:0]      cfg_data,
    ceb_sample_if.sink                          samples,
    ceb_result_if.src                           results
);
    import ceb_pkg::*;

    localparam int HALF_HODO = HODO_CHANNELS / 2;
    localparam int HCNT_W    = $clog2(HODO_CHANNELS + 1);

    // Configuration registers.
    logic [ADC_W-1:0]    hodo_threshold_reg;
    logic [ADC_W-1:0]    high_hit_level_reg;
    logic [ZS_W-1:0]     zero_suppress_reg;
    logic [ADC_W-1:0]    pulser_trigger_max_reg;
    logic [RUN_W-1:0]    pulser_run_length_reg;
    logic [SPILL_W-1:0]  spill_gap_count_reg;
    logic [ADC_W-1:0]    cherenkov_min_reg;
    logic [CH_W-1:0]     monitor_channel_reg;

    // Pipeline control.
    logic                en;
    logic                out_free;
    logic                finish;
    ceb_tag_t            tag_in;
    ceb_tag_t            s3_tag;
    logic [ENERGY_W-1:0] s3_energy;

    // Event accumulators.
    logic [HODO_CHANNELS-1:0] hit_mask_reg,   hit_mask_next;
    logic                     high_hit_reg,   high_hit_next;
    logic [SUM_W-1:0]         sum_reg,        sum_next;
    logic [ENERGY_W-1:0]      peak_value_reg, peak_value_next;
    logic [CH_W-1:0]          peak_index_reg, peak_index_next;
    logic                     peak_valid_reg, peak_valid_next;
    logic [ENERGY_W-1:0]      monitor_reg,    monitor_next;
    logic [ADC_W-1:0]         trigger_reg,    trigger_next;
    logic [ADC_W-1:0]         cherenkov_reg,  cherenkov_next;
    logic [SUM_W:0]           sum_wide;

    // Snapshot of a finished event.
    logic                     s4_valid_reg;
    logic [HODO_CHANNELS-1:0] s4_mask_reg;
    logic                     s4_high_reg;
    logic [SUM_W-1:0]         s4_sum_reg;
    logic [CH_W-1:0]          s4_peak_reg;
    logic [ENERGY_W-1:0]      s4_monitor_reg;
    logic [ADC_W-1:0]         s4_trigger_reg;
    logic [ADC_W-1:0]         s4_cherenkov_reg;

    // Run bookkeeping across events.
    logic [POS_W-1:0]    last_row_reg,    last_row_next;
    logic [POS_W-1:0]    last_column_reg, last_column_next;
    logic [RUN_W-1:0]    pulser_run_reg,  pulser_run_next;
    logic [SPILL_W-1:0]  nonpulser_reg,   nonpulser_next;
    logic [SPILL_W-1:0]  spill_reg,       spill_next;
    logic [SPILL_W-1:0]  nonpulser_step;

    // Event finishing logic.
    logic [HCNT_W-1:0]   rows;
    logic [HCNT_W-1:0]   cols;
    logic [POS_W-1:0]    hi_row;
    logic [POS_W-1:0]    hi_col;
    logic                pulser;
    logic                accepted;

    // Output register.
    logic                out_valid_reg;
    logic                out_accepted_reg;
    logic                out_electron_reg;
    logic [COUNT_W-1:0]  out_rows_reg;
    logic [COUNT_W-1:0]  out_cols_reg;
    logic [POS_W-1:0]    out_row_index_reg;
    logic [POS_W-1:0]    out_col_index_reg;
    logic                out_high_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic [CH_W-1:0]     out_peak_reg;
    logic [ENERGY_W-1:0] out_monitor_reg;
    logic [SPILL_W-1:0]  out_spill_reg;

    // The pipeline only holds when a finished event cannot move into a full output register.
    assign out_free      = !out_valid_reg || results.ready;
    assign finish        = s4_valid_reg && out_free;
    assign en            = !s4_valid_reg || out_free;
    assign samples.ready = en;

    always_comb
    begin
        tag_in.valid   = samples.valid && en;
        tag_in.cmd     = samples.cmd;
        tag_in.source  = source_t'(samples.source);
        tag_in.channel = samples.channel;
        tag_in.adc     = samples.adc;
        tag_in.eoe     = samples.end_of_event;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hodo_threshold_reg     <= RST_HODO_THRESHOLD;
            high_hit_level_reg     <= RST_HIGH_HIT_LEVEL;
            zero_suppress_reg      <= RST_ZERO_SUPPRESS;
            pulser_trigger_max_reg <= RST_PULSER_TRIGGER_MAX;
            pulser_run_length_reg  <= RST_PULSER_RUN_LENGTH;
            spill_gap_count_reg    <= RST_SPILL_GAP_COUNT;
            cherenkov_min_reg      <= RST_CHERENKOV_MIN;
            monitor_channel_reg    <= RST_MONITOR_CHANNEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HODO_THRESHOLD:     hodo_threshold_reg     <= cfg_data[ADC_W-1:0];
                REG_HIGH_HIT_LEVEL:     high_hit_level_reg     <= cfg_data[ADC_W-1:0];
                REG_ZERO_SUPPRESS:      zero_suppress_reg      <= cfg_data[ZS_W-1:0];
                REG_PULSER_TRIGGER_MAX: pulser_trigger_max_reg <= cfg_data[ADC_W-1:0];
                REG_PULSER_RUN_LENGTH:  pulser_run_length_reg  <= cfg_data[RUN_W-1:0];
                REG_SPILL_GAP_COUNT:    spill_gap_count_reg    <= cfg_data[SPILL_W-1:0];
                REG_CHERENKOV_MIN:      cherenkov_min_reg      <= cfg_data[ADC_W-1:0];
                REG_MONITOR_CHANNEL:    monitor_channel_reg    <= cfg_data[CH_W-1:0];
                default:                ;
            endcase
        end
    end

    // Calibration memories and the energy pipeline.
    ceb_energy #(
        .CAL_CHANNELS (CAL_CHANNELS)
    ) u_energy (
        .clk                 (clk),
        .rst_n               (rst_n),
        .en                  (en),
        .tag_in              (tag_in),
        .pedestal            (samples.pedestal),
        .gain                (samples.gain),
        .zero_suppress_level (zero_suppress_reg),
        .tag_out             (s3_tag),
        .energy              (s3_energy)
    );

    // Fold the item leaving the energy pipeline into the event accumulators.
    always_comb
    begin
        hit_mask_next   = hit_mask_reg;
        high_hit_next   = high_hit_reg;
        sum_next        = sum_reg;
        peak_value_next = peak_value_reg;
        peak_index_next = peak_index_reg;
        peak_valid_next = peak_valid_reg;
        monitor_next    = monitor_reg;
        trigger_next    = trigger_reg;
        cherenkov_next  = cherenkov_reg;
        sum_wide        = {1'b0, sum_reg} + (SUM_W + 1)'(s3_energy);

        if (s3_tag.valid && (s3_tag.cmd == CMD_SAMPLE))
        begin
            case (s3_tag.source)
                SRC_HODO:
                begin
                    if (32'(s3_tag.channel) < HODO_CHANNELS)
                    begin
                        for (int i = 0; i < HODO_CHANNELS; i++)
                        begin
                            if ((s3_tag.adc >= hodo_threshold_reg) && (32'(s3_tag.channel) == i))
                            begin
                                hit_mask_next[i] = 1'b1;
                            end
                        end
                        if (s3_tag.adc > high_hit_level_reg)
                        begin
                            high_hit_next = 1'b1;
                        end
                    end
                end
                SRC_CAL:
                begin
                    if (32'(s3_tag.channel) < CAL_CHANNELS)
                    begin
                        // The event sum saturates instead of wrapping.
                        sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                        // Ties go to the lower channel number.
                        if (!peak_valid_reg || (s3_energy > peak_value_reg) ||
                            ((s3_energy == peak_value_reg) && (s3_tag.channel < peak_index_reg)))
                        begin
                            peak_value_next = s3_energy;
                            peak_index_next = s3_tag.channel;
                            peak_valid_next = 1'b1;
                        end
                        if (s3_tag.channel == monitor_channel_reg)
                        begin
                            monitor_next = s3_energy;
                        end
                    end
                end
                SRC_TRIG: trigger_next   = s3_tag.adc;
                SRC_CHER: cherenkov_next = s3_tag.adc;
                default:  ;
            endcase
        end
    end

    // At the end of an event the accumulated values move to the finishing stage and the
    // accumulators start over for the next event in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_mask_reg   <= '0;
            high_hit_reg   <= 1'b0;
            sum_reg        <= '0;
            peak_value_reg <= '0;
            peak_index_reg <= '0;
            peak_valid_reg <= 1'b0;
            monitor_reg    <= '0;
            trigger_reg    <= '0;
            cherenkov_reg  <= '0;
            s4_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_tag.valid && s3_tag.eoe;
            if (s3_tag.valid && s3_tag.eoe)
            begin
                hit_mask_reg   <= '0;
                high_hit_reg   <= 1'b0;
                sum_reg        <= '0;
                peak_value_reg <= '0;
                peak_index_reg <= '0;
                peak_valid_reg <= 1'b0;
                monitor_reg    <= '0;
                trigger_reg    <= '0;
                cherenkov_reg  <= '0;
            end
            else
            begin
                hit_mask_reg   <= hit_mask_next;
                high_hit_reg   <= high_hit_next;
                sum_reg        <= sum_next;
                peak_value_reg <= peak_value_next;
                peak_index_reg <= peak_index_next;
                peak_valid_reg <= peak_valid_next;
                monitor_reg    <= monitor_next;
                trigger_reg    <= trigger_next;
                cherenkov_reg  <= cherenkov_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s3_tag.valid && s3_tag.eoe)
        begin
            s4_mask_reg      <= hit_mask_next;
            s4_high_reg      <= high_hit_next;
            s4_sum_reg       <= sum_next;
            s4_peak_reg      <= peak_index_next;
            s4_monitor_reg   <= monitor_next;
            s4_trigger_reg   <= trigger_next;
            s4_cherenkov_reg <= cherenkov_next;
        end
    end

    // Count the hit rows and columns and find the highest of each.
    always_comb
    begin
        rows   = '0;
        cols   = '0;
        hi_row = '0;
        hi_col = '0;
        for (int i = 0; i < HODO_CHANNELS; i++)
        begin
            if (s4_mask_reg[i])
            begin
                if (i < HALF_HODO)
                begin
                    rows   = rows + HCNT_W'(1);
                    hi_row = POS_W'(i);
                end
                else
                begin
                    cols   = cols + HCNT_W'(1);
                    hi_col = POS_W'(i - HALF_HODO);
                end
            end
        end
    end

    // Pulser and spill bookkeeping. An empty event with a quiet trigger counter is a pulser
    // event; a long enough run of them restarts the non-pulser count, and the spill number
    // advances when that count reaches the spill gap.
    always_comb
    begin
        accepted = (rows == HCNT_W'(1)) && (cols == HCNT_W'(1));
        pulser   = (s4_trigger_reg < pulser_trigger_max_reg) && (rows == '0) && (cols == '0);

        if ((rows != '0) && (cols != '0))
        begin
            last_row_next    = hi_row;
            last_column_next = hi_col;
        end
        else
        begin
            last_row_next    = last_row_reg;
            last_column_next = last_column_reg;
        end

        if (pulser)
        begin
            pulser_run_next = (pulser_run_reg != '1) ? pulser_run_reg + RUN_W'(1) : pulser_run_reg;
            nonpulser_step  = nonpulser_reg;
        end
        else
        begin
            pulser_run_next = '0;
            nonpulser_step  = (nonpulser_reg != '1) ? nonpulser_reg + SPILL_W'(1) : nonpulser_reg;
        end

        nonpulser_next = (pulser_run_next >= pulser_run_length_reg) ? '0 : nonpulser_step;

        if ((nonpulser_next == spill_gap_count_reg) && (spill_reg != '1))
        begin
            spill_next = spill_reg + SPILL_W'(1);
        end
        else
        begin
            spill_next = spill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg    <= '0;
            last_column_reg <= '0;
            pulser_run_reg  <= '0;
            nonpulser_reg   <= '0;
            spill_reg       <= SPILL_W'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                last_row_reg    <= last_row_next;
                last_column_reg <= last_column_next;
                pulser_run_reg  <= pulser_run_next;
                nonpulser_reg   <= nonpulser_next;
                spill_reg       <= spill_next;
                out_valid_reg   <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_accepted_reg  <= accepted;
            out_electron_reg  <= accepted && (s4_cherenkov_reg > cherenkov_min_reg);
            out_rows_reg      <= (rows > HCNT_W'(15)) ? '1 : COUNT_W'(rows);
            out_cols_reg      <= (cols > HCNT_W'(15)) ? '1 : COUNT_W'(cols);
            out_row_index_reg <= last_row_next;
            out_col_index_reg <= last_column_next;
            out_high_reg      <= s4_high_reg;
            out_sum_reg       <= s4_sum_reg;
            out_peak_reg      <= s4_peak_reg;
            out_monitor_reg   <= s4_monitor_reg;
            out_spill_reg     <= spill_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.event_accepted = out_accepted_reg;
    assign results.electron_flag  = out_electron_reg;
    assign results.row_count      = out_rows_reg;
    assign results.column_count   = out_cols_reg;
    assign results.row_index      = out_row_index_reg;
    assign results.column_index   = out_col_index_reg;
    assign results.high_hit       = out_high_reg;
    assign results.energy_sum     = out_sum_reg;
    assign results.peak_tower     = out_peak_reg;
    assign results.monitor_energy = out_monitor_reg;
    assign results.spill_number   = out_spill_reg;

endmodule
